>>> hw/rtl/ascon128_aead_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Ascon-128 block
// Clocked on clk and disabled while arst_n is low, in the module that uses them.
// ---------------------------------------------------------------------------
`ifndef ASCON128_AEAD_DEFINES_SVH
`define ASCON128_AEAD_DEFINES_SVH

// Check a property on every rising edge of clk outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> hw/rtl/ascon_pkg.sv
// ---------------------------------------------------------------------------
// ascon_pkg
// Types, codes and round helpers shared by the Ascon-128 block.
// ---------------------------------------------------------------------------
`default_nettype none

package ascon_pkg;

	localparam int LANE_W    = 64;
	localparam int NUM_LANES = 5;
	localparam int RND_W     = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [RND_W-1:0] FIRST_ROUND_FULL = 4'd0;
	localparam logic [RND_W-1:0] FIRST_ROUND_HALF = 4'd6;
	localparam logic [RND_W-1:0] LAST_ROUND       = 4'd11;

	localparam logic [LANE_W-1:0] IV_ASCON128 = 64'h80400c0600000000;
	localparam logic [LANE_W-1:0] PAD_BIT     = 64'h8000000000000000;
	localparam logic [LANE_W-1:0] DOMAIN_SEP  = 64'h0000000000000001;

	// Operating modes
	localparam logic [2:0] MODE_START  = 3'd0;
	localparam logic [2:0] MODE_AD     = 3'd1;
	localparam logic [2:0] MODE_AD_END = 3'd2;
	localparam logic [2:0] MODE_ENC    = 3'd3;
	localparam logic [2:0] MODE_DEC    = 3'd4;
	localparam logic [2:0] MODE_TAG    = 3'd5;
	localparam logic [2:0] MODE_VERIFY = 3'd6;

	// Result kinds
	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_TAG    = 2'd1;
	localparam logic [1:0] KIND_VERIFY = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'd1;

	typedef logic [NUM_LANES-1:0][LANE_W-1:0] lanes_t;

	typedef struct packed {
		logic [2:0]        mode;
		logic [LANE_W-1:0] block;
		logic [LANE_W-1:0] nonce_high;
		logic [LANE_W-1:0] nonce_low;
		logic [LANE_W-1:0] expected_tag_high;
		logic [LANE_W-1:0] expected_tag_low;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]        result_kind;
		logic [LANE_W-1:0] out_block;
		logic [LANE_W-1:0] tag_high;
		logic [LANE_W-1:0] tag_low;
		logic              tag_match;
	} out_beat_t;

	// Round constant: high nibble counts down, low nibble counts up
	function automatic logic [7:0] round_const(input logic [RND_W-1:0] r);
		logic [RND_W-1:0] hi;
		hi = 4'hf - r;
		return {hi, r};
	endfunction

	function automatic logic [LANE_W-1:0] rotr(input logic [LANE_W-1:0] x, input int n);
		return (x >> n) | (x << (LANE_W - n));
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ascon_round.sv
// ---------------------------------------------------------------------------
// ascon_round
// One Ascon permutation round: constant addition, S-box layer, linear layer.
// ---------------------------------------------------------------------------
`default_nettype none

module ascon_round (
	input  wire ascon_pkg::lanes_t              cur,
	input  wire logic [ascon_pkg::RND_W-1:0]    rnd,
	output ascon_pkg::lanes_t                   nxt
);

	logic [ascon_pkg::LANE_W-1:0] x0, x1, x2, x3, x4;
	logic [ascon_pkg::LANE_W-1:0] t0, t1, t2, t3, t4;
	logic [ascon_pkg::LANE_W-1:0] y0, y1, y2, y3, y4;

	always_comb begin
		x0 = cur[0];
		x1 = cur[1];
		x2 = cur[2] ^ {56'd0, ascon_pkg::round_const(rnd)};
		x3 = cur[3];
		x4 = cur[4];

		// S-box, bit-sliced across the lanes
		x0 = x0 ^ x4;
		x4 = x4 ^ x3;
		x2 = x2 ^ x1;
		t0 = ~x0 & x1;
		t1 = ~x1 & x2;
		t2 = ~x2 & x3;
		t3 = ~x3 & x4;
		t4 = ~x4 & x0;
		y0 = x0 ^ t1;
		y1 = x1 ^ t2;
		y2 = x2 ^ t3;
		y3 = x3 ^ t4;
		y4 = x4 ^ t0;
		y1 = y1 ^ y0;
		y0 = y0 ^ y4;
		y3 = y3 ^ y2;
		y2 = ~y2;

		// Linear diffusion per lane
		nxt[0] = y0 ^ ascon_pkg::rotr(y0, 19) ^ ascon_pkg::rotr(y0, 28);
		nxt[1] = y1 ^ ascon_pkg::rotr(y1, 61) ^ ascon_pkg::rotr(y1, 39);
		nxt[2] = y2 ^ ascon_pkg::rotr(y2, 1)  ^ ascon_pkg::rotr(y2, 6);
		nxt[3] = y3 ^ ascon_pkg::rotr(y3, 10) ^ ascon_pkg::rotr(y3, 17);
		nxt[4] = y4 ^ ascon_pkg::rotr(y4, 7)  ^ ascon_pkg::rotr(y4, 41);
	end

endmodule

`default_nettype wire

>>> hw/rtl/ascon128_aead.sv
// ---------------------------------------------------------------------------
// ascon128_aead
// Ascon-128 authenticated encryption over whole 64-bit blocks.
// ---------------------------------------------------------------------------
// Usage: write the key through the configuration port (index 0 upper half,
//   index 1 lower half) while the block is idle, then send beats on the input
//   channel: start, any AD blocks, AD end, encrypt or decrypt blocks, then
//   finish tag or finish verify. Each beat carries a mode and its fields.
//   Encrypt, decrypt and the two finish modes give one result beat; start,
//   AD block and AD end give none; mode 7 is dropped at acceptance.
// Timing: one permutation round per cycle through a single shared round
//   unit, so a beat takes a load step, 6 or 12 rounds and a finishing
//   step: 6 rounds for AD, AD end, encrypt and decrypt, 12 for start and
//   finish. The result appears in the output register on the finishing edge.
//   in_ready is high only while the sequencer is idle.
// Stalls and reset: a result waits in the output register; the next beat is
//   accepted and worked on meanwhile, and only its finishing step holds
//   until the output register is free. Reset clears the lanes, key and
//   sequencer and empties the output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "ascon128_aead_defines.svh"

module ascon128_aead (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire ascon_pkg::in_beat_t                 in_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output ascon_pkg::out_beat_t                     out_data,
	input  wire logic                                cfg_wr_en,
	input  wire logic [ascon_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  wire logic [ascon_pkg::LANE_W-1:0]        cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t                        state_q;
	logic [ascon_pkg::RND_W-1:0]   rnd_q;
	ascon_pkg::lanes_t             lanes_q;
	ascon_pkg::lanes_t             round_out;
	logic [2:0]                    mode_q;
	logic [ascon_pkg::LANE_W-1:0]  data_q;
	logic [ascon_pkg::LANE_W-1:0]  exp_high_q, exp_low_q;
	logic [ascon_pkg::LANE_W-1:0]  key_high_q, key_low_q;
	logic                          out_valid_q;
	ascon_pkg::out_beat_t          out_q;
	ascon_pkg::out_beat_t          result_d;

	logic                          accept;
	logic                          has_result;
	logic                          slot_free;
	logic                          leave_fin;
	logic [ascon_pkg::LANE_W-1:0]  tag_high, tag_low;

	// Shared round unit
	ascon_round u_round (
		.cur (lanes_q),
		.rnd (rnd_q),
		.nxt (round_out)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign has_result = (mode_q == ascon_pkg::MODE_ENC) || (mode_q == ascon_pkg::MODE_DEC)
		|| (mode_q == ascon_pkg::MODE_TAG) || (mode_q == ascon_pkg::MODE_VERIFY);
	assign slot_free  = !out_valid_q || out_ready;
	assign leave_fin  = (state_q == ST_FIN) && (!has_result || slot_free);

	// Tag is the last two lanes keyed once more
	assign tag_high = lanes_q[3] ^ key_high_q;
	assign tag_low  = lanes_q[4] ^ key_low_q;

	// Key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				ascon_pkg::REG_KEY_HIGH: key_high_q <= cfg_wdata;
				ascon_pkg::REG_KEY_LOW:  key_low_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Sequencer and lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
			lanes_q <= '0;
			mode_q  <= ascon_pkg::MODE_START;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q <= in_data.mode;
						case (in_data.mode) inside
							ascon_pkg::MODE_START: begin
								lanes_q[0] <= ascon_pkg::IV_ASCON128;
								lanes_q[1] <= key_high_q;
								lanes_q[2] <= key_low_q;
								lanes_q[3] <= in_data.nonce_high;
								lanes_q[4] <= in_data.nonce_low;
								rnd_q      <= ascon_pkg::FIRST_ROUND_FULL;
								state_q    <= ST_RUN;
							end
							ascon_pkg::MODE_AD, ascon_pkg::MODE_ENC: begin
								lanes_q[0] <= lanes_q[0] ^ in_data.block;
								rnd_q      <= ascon_pkg::FIRST_ROUND_HALF;
								state_q    <= ST_RUN;
							end
							ascon_pkg::MODE_AD_END: begin
								lanes_q[0] <= lanes_q[0] ^ ascon_pkg::PAD_BIT;
								rnd_q      <= ascon_pkg::FIRST_ROUND_HALF;
								state_q    <= ST_RUN;
							end
							ascon_pkg::MODE_DEC: begin
								lanes_q[0] <= in_data.block;
								rnd_q      <= ascon_pkg::FIRST_ROUND_HALF;
								state_q    <= ST_RUN;
							end
							ascon_pkg::MODE_TAG, ascon_pkg::MODE_VERIFY: begin
								lanes_q[0] <= lanes_q[0] ^ ascon_pkg::PAD_BIT;
								lanes_q[1] <= lanes_q[1] ^ key_high_q;
								lanes_q[2] <= lanes_q[2] ^ key_low_q;
								rnd_q      <= ascon_pkg::FIRST_ROUND_FULL;
								state_q    <= ST_RUN;
							end
							default: ; // unused mode: drop the beat, stay idle
						endcase
					end
				end
				ST_RUN: begin
					lanes_q <= round_out;
					if (rnd_q == ascon_pkg::LAST_ROUND) begin
						rnd_q   <= '0;
						state_q <= ST_FIN;
					end else begin
						rnd_q <= rnd_q + 1'b1;
					end
				end
				ST_FIN: begin
					// hold here while a result cannot be placed
					if (leave_fin) begin
						state_q <= ST_IDLE;
						case (mode_q) inside
							ascon_pkg::MODE_START, ascon_pkg::MODE_TAG,
							ascon_pkg::MODE_VERIFY: begin
								lanes_q[3] <= tag_high;
								lanes_q[4] <= tag_low;
							end
							ascon_pkg::MODE_AD_END: begin
								lanes_q[4] <= lanes_q[4] ^ ascon_pkg::DOMAIN_SEP;
							end
							default: ;
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Beat payload kept for the finishing step
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q     <= in_data.block ^ lanes_q[0];
			exp_high_q <= in_data.expected_tag_high;
			exp_low_q  <= in_data.expected_tag_low;
		end
	end

	// Result beat; fields with no meaning for the kind stay zero
	always_comb begin
		result_d = '0;
		case (mode_q) inside
			ascon_pkg::MODE_ENC, ascon_pkg::MODE_DEC: begin
				result_d.result_kind = ascon_pkg::KIND_DATA;
				result_d.out_block   = data_q;
			end
			ascon_pkg::MODE_TAG: begin
				result_d.result_kind = ascon_pkg::KIND_TAG;
				result_d.tag_high    = tag_high;
				result_d.tag_low     = tag_low;
			end
			default: begin
				result_d.result_kind = ascon_pkg::KIND_VERIFY;
				result_d.tag_match   = (tag_high == exp_high_q) && (tag_low == exp_low_q);
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (leave_fin && has_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (leave_fin && has_result) begin
			out_q <= result_d;
		end
	end

	`ASSERT_CLK(a_idle_rnd_zero, (state_q == ST_IDLE) |-> (rnd_q == '0), "round counter not cleared in idle")
	`ASSERT_NEVER(a_rnd_range, rnd_q > ascon_pkg::LAST_ROUND, "round counter beyond last round")
	`ASSERT_CLK(a_out_from_fin, $rose(out_valid_q) |-> $past(state_q == ST_FIN), "result raised outside finishing step")
	`ASSERT_CLK(a_fin_hold, ((state_q == ST_FIN) && has_result && !slot_free) |=> (state_q == ST_FIN), "finishing step left with output busy")

endmodule

`default_nettype wire
